// ===== sv/prse_pkg.sv =====
// ----------------------------------------------------------------------------
// prse_pkg
// Types and constants shared by the pixel run span extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package prse_pkg;

  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned POS_W      = 12;  // span_row, span_start
  localparam int unsigned LEN_W      = 13;  // span_length
  localparam int unsigned SIZE_W     = 13;  // image_width, image_height
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH       = 3'd0,
    REG_IMAGE_HEIGHT      = 3'd1,
    REG_TRANSPARENT_COLOR = 3'd2,
    REG_USE_BITMAP        = 3'd3,
    REG_SPLIT_ON_COLOR    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               select_bit;
  } pixel_t;

  typedef struct packed {
    logic [POS_W-1:0]   span_row;
    logic [POS_W-1:0]   span_start;
    logic [LEN_W-1:0]   span_length;
    logic [COLOR_W-1:0] span_color;
    logic               last_of_item;
  } span_t;

endpackage

`default_nettype wire

// ===== sv/pixel_run_span_extractor_core.sv =====
// ----------------------------------------------------------------------------
// pixel_run_span_extractor_core
// Merges a raster pixel stream into horizontal spans of selected pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per beat (color + select bit) in traversal order.
//   out_* : spans as row, start column, length and first color. One pixel
//           yields zero, one or two spans; last_of_item marks the final span
//           of a pixel. Spans come out in order through a 4-deep queue.
//   cfg_* : write-only registers, written while the block is idle.
// Timing:
//   A pixel is evaluated in the cycle it is accepted; its spans sit in the
//   output queue the next cycle. One pixel per cycle is taken while the queue
//   holds at most two spans, so the sustained rate is one pixel per cycle as
//   long as spans average at most one per cycle and out_stall stays low;
//   output is limited to one span per cycle by the single queue read port.
// Reset:
//   rst_n low clears counters, the open span, the queue and the registers
//   (width 1, height 1, transparent color 0, both modes off). in_stall is
//   high during reset. A stalled out_data holds; the input stalls once the
//   queue has fewer than two free entries.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_run_span_extractor_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire prse_pkg::pixel_t                    in_data,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      prse_pkg::span_t                     out_data,
  input  wire logic                                cfg_we,
  input  wire logic [prse_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [prse_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned SW  = prse_pkg::SIZE_W;
  localparam int unsigned CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WCW = ((CW > SW) ? CW : SW) + 1;
  localparam int unsigned WRW = ((RW > SW) ? RW : SW) + 1;
  localparam int unsigned LW  = ((CW + 1) > prse_pkg::LEN_W) ? (CW + 1) : prse_pkg::LEN_W;
  localparam int unsigned PW  = (CW > prse_pkg::POS_W) ? CW : prse_pkg::POS_W;
  localparam int unsigned PRW = (RW > prse_pkg::POS_W) ? RW : prse_pkg::POS_W;

  // configuration
  logic [SW-1:0]                    cfg_width_r;
  logic [SW-1:0]                    cfg_height_r;
  logic [prse_pkg::COLOR_W-1:0]     cfg_tcolor_r;
  logic                             cfg_bitmap_r;
  logic                             cfg_split_r;

  // scan state
  logic [CW-1:0]                    col_r, col_nxt;
  logic [RW-1:0]                    row_r, row_nxt;
  logic                             open_r, open_nxt;
  logic [CW-1:0]                    open_start_r, open_start_nxt;
  logic [prse_pkg::COLOR_W-1:0]     open_color_r, open_color_nxt;

  // output queue
  prse_pkg::span_t                  fifo_r [prse_pkg::FIFO_DEPTH];
  logic [prse_pkg::FIFO_PTR_W-1:0]  wptr_r, rptr_r;
  logic [prse_pkg::FIFO_CNT_W-1:0]  count_r, count_nxt;

  logic                             in_accept, out_pop;
  logic [WCW-1:0]                   w_ext, w_eff, w_m1;
  logic [WRW-1:0]                   h_ext, h_eff, h_m1;
  logic                             selected, close0, keep_open, open_b, row_end, close1;
  logic [CW-1:0]                    start_a;
  logic [prse_pkg::COLOR_W-1:0]     color_a;
  logic [LW-1:0]                    len0_ext, len1_ext;
  logic [PW-1:0]                    start0_ext, start1_ext;
  logic [PRW-1:0]                   row_ext;
  prse_pkg::span_t                  span0, span1, push_a, push_b;
  logic [1:0]                       push_n;

  assign in_stall  = !rst_n || (count_r > prse_pkg::FIFO_CNT_W'(prse_pkg::FIFO_DEPTH - 2));
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign out_data  = fifo_r[rptr_r];

  // effective frame size: zero acts as one, oversize clamps to the maximum
  always_comb begin
    w_ext = WCW'(cfg_width_r);
    if (w_ext == '0) begin
      w_eff = WCW'(1);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_m1 = w_eff - WCW'(1);

    h_ext = WRW'(cfg_height_r);
    if (h_ext == '0) begin
      h_eff = WRW'(1);
    end else if (h_ext > WRW'(MAX_HEIGHT)) begin
      h_eff = WRW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    h_m1 = h_eff - WRW'(1);
  end

  // span decision for the pixel on the input port
  always_comb begin
    selected = cfg_bitmap_r ? in_data.select_bit : (in_data.pixel_color != cfg_tcolor_r);
    close0   = open_r && (!selected ||
                          (cfg_split_r && (in_data.pixel_color != open_color_r)));
    keep_open = open_r && !close0;
    start_a   = keep_open ? open_start_r : col_r;
    color_a   = keep_open ? open_color_r : in_data.pixel_color;
    open_b    = keep_open || selected;
    row_end   = (WCW'(col_r) >= w_m1);
    close1    = row_end && open_b;

    len0_ext   = LW'(col_r) - LW'(open_start_r);
    len1_ext   = LW'(col_r) + LW'(1) - LW'(start_a);
    start0_ext = PW'(open_start_r);
    start1_ext = PW'(start_a);
    row_ext    = PRW'(row_r);

    span0.span_row     = row_ext[prse_pkg::POS_W-1:0];
    span0.span_start   = start0_ext[prse_pkg::POS_W-1:0];
    span0.span_length  = len0_ext[prse_pkg::LEN_W-1:0];
    span0.span_color   = open_color_r;
    span0.last_of_item = !close1;

    span1.span_row     = row_ext[prse_pkg::POS_W-1:0];
    span1.span_start   = start1_ext[prse_pkg::POS_W-1:0];
    span1.span_length  = len1_ext[prse_pkg::LEN_W-1:0];
    span1.span_color   = color_a;
    span1.last_of_item = 1'b1;

    push_a = close0 ? span0 : span1;
    push_b = span1;
    push_n = in_accept ? ({1'b0, close0} + {1'b0, close1}) : 2'd0;

    open_nxt       = open_b && !row_end;
    open_start_nxt = start_a;
    open_color_nxt = color_a;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = (WRW'(row_r) >= h_m1) ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end

    count_nxt = count_r + prse_pkg::FIFO_CNT_W'(push_n)
              - prse_pkg::FIFO_CNT_W'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= SW'(1);
      cfg_height_r <= SW'(1);
      cfg_tcolor_r <= '0;
      cfg_bitmap_r <= 1'b0;
      cfg_split_r  <= 1'b0;
    end else if (cfg_we) begin
      case (prse_pkg::cfg_reg_t'(cfg_addr))
        prse_pkg::REG_IMAGE_WIDTH:       cfg_width_r  <= cfg_wdata[SW-1:0];
        prse_pkg::REG_IMAGE_HEIGHT:      cfg_height_r <= cfg_wdata[SW-1:0];
        prse_pkg::REG_TRANSPARENT_COLOR: cfg_tcolor_r <= cfg_wdata[prse_pkg::COLOR_W-1:0];
        prse_pkg::REG_USE_BITMAP:        cfg_bitmap_r <= cfg_wdata[0];
        prse_pkg::REG_SPLIT_ON_COLOR:    cfg_split_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      open_r       <= 1'b0;
      open_start_r <= '0;
      open_color_r <= '0;
    end else if (in_accept) begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      open_r       <= open_nxt;
      open_start_r <= open_start_nxt;
      open_color_r <= open_color_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + prse_pkg::FIFO_PTR_W'(push_n);
      rptr_r  <= rptr_r + prse_pkg::FIFO_PTR_W'(out_pop);
      count_r <= count_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      fifo_r[wptr_r + prse_pkg::FIFO_PTR_W'(1)] <= push_b;
    end
  end

endmodule

`default_nettype wire

// ===== sv/prse_checker.sv =====
// ----------------------------------------------------------------------------
// prse_checker
// Port-level checks for the pixel run span extractor, bound to pixel_run_span_extractor_core.
// ----------------------------------------------------------------------------
`default_nettype none

module prse_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire prse_pkg::span_t out_data,
  input wire logic            out_valid,
  input wire logic            out_stall
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled span changed or dropped");

  // second span of a pixel is queued together with the first
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_item |=> out_valid)
    else $error("second span of a pixel not ready after the first");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.span_length != '0)
    else $error("span of zero length");

  // first edge out of reset: queue empty, input open
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) && rst_n |-> !out_valid && !in_stall)
    else $error("output not empty after reset");

  // no input taken while in reset
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |-> in_stall || !in_valid)
    else $error("input accepted during reset");

endmodule

bind pixel_run_span_extractor_core prse_checker u_prse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

`default_nettype wire
